// ===== rtl/core/ccc_pkg.sv =====
// Shared types, constants and calendar helper functions for the
// calendar clock counter. No dependencies.
package ccc_pkg;

    // Default last year that the counter can reach
    localparam int unsigned CCC_YEAR_MAX = 9999;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int H12_W    = 4;

    // Last values before a carry
    localparam logic [SECOND_W-1:0] SEC_LAST   = SECOND_W'(59);
    localparam logic [MINUTE_W-1:0] MIN_LAST   = MINUTE_W'(59);
    localparam logic [HOUR_W-1:0]   HOUR_LAST  = HOUR_W'(23);
    localparam logic [HOUR_W-1:0]   HOUR_NOON  = HOUR_W'(12);
    localparam logic [MONTH_W-1:0]  MONTH_LAST = MONTH_W'(12);
    localparam logic [H12_W-1:0]    H12_TOP    = H12_W'(12);

    // Reset date: 2000-01-01 00:00:00
    localparam logic [YEAR_W-1:0]   YEAR_RST  = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0]  MONTH_RST = MONTH_W'(1);
    localparam logic [DAY_W-1:0]    DAY_RST   = DAY_W'(1);

    // Divisibility by 25: q = (y * 5243) >> 17 is exact for y < 2**14
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;
    localparam int DIV25_PW    = YEAR_W + 13;
    localparam int DIV25_QW    = DIV25_PW - DIV25_SHIFT;

    localparam logic [DAY_W-1:0] FEB_LEAP_LEN = DAY_W'(29);

    // Days per month, index 0 means an invalid month
    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        DAY_W'(0),  DAY_W'(31), DAY_W'(28), DAY_W'(31),
        DAY_W'(30), DAY_W'(31), DAY_W'(30), DAY_W'(31),
        DAY_W'(31), DAY_W'(30), DAY_W'(31), DAY_W'(30),
        DAY_W'(31), DAY_W'(0),  DAY_W'(0),  DAY_W'(0)
    };

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_YEAR_ZERO = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_BAD_HOUR  = 3'd4,
        ST_BAD_MIN   = 3'd5,
        ST_BAD_SEC   = 3'd6,
        ST_YEAR_OVF  = 3'd7
    } status_t;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } cal_t;

    typedef struct packed {
        cal_t              cal;
        logic [H12_W-1:0]  hour_twelve;
        logic              is_pm;
        status_t           status;
    } result_t;

    // Gregorian leap rule: y%4==0 and (y%25!=0 or y%16==0)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [DIV25_PW-1:0] prod;
        logic [DIV25_QW-1:0] q;
        logic [YEAR_W-1:0]   rem;
        prod = DIV25_PW'(y) * DIV25_PW'(DIV25_MUL);
        q    = prod[DIV25_PW-1:DIV25_SHIFT];
        // q*25 as shift-adds
        rem  = y - YEAR_W'({q, 4'b0} + {q, 3'b0} + q);
        return (y[1:0] == 2'b00) && ((rem != '0) || (y[3:0] == 4'b0000));
    endfunction

    // Month length, 0 for an invalid month
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if ((m == MONTH_FEB) && leap)
        begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

endpackage

// ===== rtl/core/ccc_update.sv =====
// Next-state logic of the calendar clock: tick carry chain, checked load,
// 12-hour view and status. Combinational. Depends on ccc_pkg.
module ccc_update
    import ccc_pkg::*;
#(
    parameter int unsigned YEAR_MAX = CCC_YEAR_MAX
)
(
    input  cmd_t    cmd,
    input  cal_t    cur,
    input  cal_t    set,
    output result_t res
);

    localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);

    logic             cur_leap;
    logic             set_leap;
    logic [DAY_W-1:0] cur_len;
    logic [DAY_W-1:0] set_len;
    cal_t             nxt;
    status_t          st;
    logic [HOUR_W-1:0] h_mod;

    assign cur_leap = is_leap(cur.year);
    assign set_leap = is_leap(set.year);
    assign cur_len  = days_in(cur.month, cur_leap);
    assign set_len  = days_in(set.month, set_leap);

    // Tick carry chain or checked load
    always_comb
    begin
        nxt = cur;
        st  = ST_OK;
        unique case (cmd)
            CMD_TICK:
            begin
                if (cur.second < SEC_LAST)
                begin
                    nxt.second = cur.second + 1'b1;
                end
                else
                begin
                    nxt.second = '0;
                    if (cur.minute < MIN_LAST)
                    begin
                        nxt.minute = cur.minute + 1'b1;
                    end
                    else
                    begin
                        nxt.minute = '0;
                        if (cur.hour < HOUR_LAST)
                        begin
                            nxt.hour = cur.hour + 1'b1;
                        end
                        else
                        begin
                            nxt.hour = '0;
                            if (cur.day < cur_len)
                            begin
                                nxt.day = cur.day + 1'b1;
                            end
                            else
                            begin
                                nxt.day = DAY_RST;
                                if (cur.month < MONTH_LAST)
                                begin
                                    nxt.month = cur.month + 1'b1;
                                end
                                else
                                begin
                                    nxt.month = MONTH_RST;
                                    // year holds at the limit
                                    if (cur.year >= YMAX)
                                    begin
                                        st = ST_YEAR_OVF;
                                    end
                                    else
                                    begin
                                        nxt.year = cur.year + 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            CMD_LOAD:
            begin
                // first failing field wins, nothing written on failure
                priority if (set.year == '0)
                    st = ST_YEAR_ZERO;
                else if (set.year > YMAX)
                    st = ST_YEAR_OVF;
                else if ((set.month == '0) || (set.month > MONTH_LAST))
                    st = ST_BAD_MONTH;
                else if ((set.day == '0) || (set.day > set_len))
                    st = ST_BAD_DAY;
                else if (set.hour > HOUR_LAST)
                    st = ST_BAD_HOUR;
                else if (set.minute > MIN_LAST)
                    st = ST_BAD_MIN;
                else if (set.second > SEC_LAST)
                    st = ST_BAD_SEC;
                else
                    nxt = set;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // 12-hour view
    always_comb
    begin
        if (nxt.hour >= HOUR_NOON)
        begin
            h_mod = nxt.hour - HOUR_NOON;
        end
        else
        begin
            h_mod = nxt.hour;
        end
        res.cal         = nxt;
        res.status      = st;
        res.is_pm       = (nxt.hour >= HOUR_NOON);
        res.hour_twelve = (h_mod == '0) ? H12_TOP : H12_W'(h_mod);
    end

endmodule

// ===== rtl/core/calendar_clock_counter.sv =====
// Calendar clock counter top level: input beat register, calendar state,
// result register. Depends on ccc_pkg and ccc_update.
// An accepted beat passes the input beat register, then the result register.
// Throughput: one beat per cycle unless out_stall holds a result; calendar
// state and result register load together, so the next beat sees it at once.
// Reset (rst_n low, async): date 2000-01-01 00:00:00, both stages empty.
module calendar_clock_counter
    import ccc_pkg::*;
#(
    parameter int unsigned YEAR_MAX = CCC_YEAR_MAX
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [YEAR_W-1:0]   set_year,
    input  logic [MONTH_W-1:0]  set_month,
    input  logic [DAY_W-1:0]    set_day,
    input  logic [HOUR_W-1:0]   set_hour,
    input  logic [MINUTE_W-1:0] set_minute,
    input  logic [SECOND_W-1:0] set_second,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   year_out,
    output logic [MONTH_W-1:0]  month_out,
    output logic [DAY_W-1:0]    day_out,
    output logic [HOUR_W-1:0]   hour_out,
    output logic [MINUTE_W-1:0] minute_out,
    output logic [SECOND_W-1:0] second_out,
    output logic [H12_W-1:0]    hour_twelve,
    output logic                is_pm,
    output logic [2:0]          status
);

    logic    in_valid_reg;
    logic    in_valid_next;
    cmd_t    in_cmd_reg;
    cal_t    in_set_reg;

    cal_t    cal_reg;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    logic    accept_in;
    logic    out_free;
    logic    advance;
    result_t upd_res;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    // Input beat register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_cmd_reg <= cmd_t'(cmd);
            in_set_reg <= '{year: set_year, month: set_month, day: set_day,
                            hour: set_hour, minute: set_minute,
                            second: set_second};
        end
    end

    // Next state and result
    ccc_update #(
        .YEAR_MAX (YEAR_MAX)
    ) u_update (
        .cmd (in_cmd_reg),
        .cur (cal_reg),
        .set (in_set_reg),
        .res (upd_res)
    );

    // Calendar state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '{year: YEAR_RST, month: MONTH_RST, day: DAY_RST,
                         hour: '0, minute: '0, second: '0};
        end
        else if (advance)
        begin
            cal_reg <= upd_res.cal;
        end
    end

    // Result register
    assign out_valid_next = out_free ? advance : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= upd_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign year_out    = out_res_reg.cal.year;
    assign month_out   = out_res_reg.cal.month;
    assign day_out     = out_res_reg.cal.day;
    assign hour_out    = out_res_reg.cal.hour;
    assign minute_out  = out_res_reg.cal.minute;
    assign second_out  = out_res_reg.cal.second;
    assign hour_twelve = out_res_reg.hour_twelve;
    assign is_pm       = out_res_reg.is_pm;
    assign status      = out_res_reg.status;

    // Checks
    // a rejected load leaves the calendar untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == CMD_LOAD) && (upd_res.status != ST_OK))
        |=> $stable(cal_reg))
        else $error("rejected load changed the calendar");

    // every tick moves the seconds counter
    a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_cmd_reg == CMD_TICK))
        |=> (cal_reg.second != $past(cal_reg.second)))
        else $error("tick did not advance seconds");

    // a stalled input means a beat is waiting and the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without cause");

    // the result register receives exactly what the calendar took
    a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_res_reg.cal == cal_reg))
        else $error("result and calendar state disagree");

endmodule

// ===== test/tb_calendar_clock_counter.sv =====
// Testbench for calendar_clock_counter: directed and random tick/load beats,
// results checked against an in-bench calendar predictor.
// Depends on ccc_pkg and the calendar_clock_counter RTL.
module tb_calendar_clock_counter;
    import ccc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned YEAR_LIMIT = CCC_YEAR_MAX;
    localparam int RANDOM_TARGET = 1750;
    localparam int DRAIN_CYCLES = 8;
    localparam int HANG_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    typedef struct {
        cmd_t                cmd;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                cmd = 1'b0;
    logic [YEAR_W-1:0]   set_year = '0;
    logic [MONTH_W-1:0]  set_month = '0;
    logic [DAY_W-1:0]    set_day = '0;
    logic [HOUR_W-1:0]   set_hour = '0;
    logic [MINUTE_W-1:0] set_minute = '0;
    logic [SECOND_W-1:0] set_second = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [YEAR_W-1:0]   year_out;
    logic [MONTH_W-1:0]  month_out;
    logic [DAY_W-1:0]    day_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;
    logic [SECOND_W-1:0] second_out;
    logic [H12_W-1:0]    hour_twelve;
    logic                is_pm;
    logic [2:0]          status;

    // stimulus waiting to be sent, and readings waiting to come back
    beat_t   queued_beats[$];
    result_t pending_readings[$];

    // predictor copy of the calendar
    int unsigned cal_year, cal_month, cal_day, cal_hour, cal_min, cal_sec;

    int total_items = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int fail_count = 0;
    int hang_count = 0;
    int n_ticks = 0, n_loads = 0, n_rejected = 0, n_day_carries = 0, n_overflows = 0;

    beat_t   sent_beat;
    beat_t   next_beat;
    result_t want_r;
    result_t got_r;

    calendar_clock_counter #(.YEAR_MAX(YEAR_LIMIT)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .set_year   (set_year),
        .set_month  (set_month),
        .set_day    (set_day),
        .set_hour   (set_hour),
        .set_minute (set_minute),
        .set_second (set_second),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .year_out   (year_out),
        .month_out  (month_out),
        .day_out    (day_out),
        .hour_out   (hour_out),
        .minute_out (minute_out),
        .second_out (second_out),
        .hour_twelve(hour_twelve),
        .is_pm      (is_pm),
        .status     (status)
    );

    always
    begin
        #6 clk = ~clk;
    end

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Apply one beat to the predicted calendar and return the expected reading
    function automatic result_t advance_calendar(beat_t b);
        result_t r;
        status_t st;
        st = ST_OK;
        if (b.cmd == CMD_LOAD)
        begin
            n_loads++;
            // checks in field order; first failure wins and nothing is loaded
            if (b.year == 0)
                st = ST_YEAR_ZERO;
            else if (b.year > YEAR_LIMIT)
                st = ST_YEAR_OVF;
            else if (b.month == 0 || b.month > 12)
                st = ST_BAD_MONTH;
            else if (b.day == 0 || b.day > month_days(b.month, b.year))
                st = ST_BAD_DAY;
            else if (b.hour > 23)
                st = ST_BAD_HOUR;
            else if (b.minute > 59)
                st = ST_BAD_MIN;
            else if (b.second > 59)
                st = ST_BAD_SEC;
            else
            begin
                cal_year  = b.year;
                cal_month = b.month;
                cal_day   = b.day;
                cal_hour  = b.hour;
                cal_min   = b.minute;
                cal_sec   = b.second;
            end
            if (st != ST_OK)
                n_rejected++;
        end
        else
        begin
            n_ticks++;
            cal_sec++;
            if (cal_sec == 60)
            begin
                cal_sec = 0;
                cal_min++;
                if (cal_min == 60)
                begin
                    cal_min = 0;
                    cal_hour++;
                    if (cal_hour == 24)
                    begin
                        cal_hour = 0;
                        n_day_carries++;
                        cal_day++;
                        if (cal_day > month_days(cal_month, cal_year))
                        begin
                            cal_day = 1;
                            cal_month++;
                            if (cal_month > 12)
                            begin
                                cal_month = 1;
                                // year saturates at the limit
                                if (cal_year >= YEAR_LIMIT)
                                begin
                                    st = ST_YEAR_OVF;
                                    n_overflows++;
                                end
                                else
                                    cal_year++;
                            end
                        end
                    end
                end
            end
        end
        r.cal.year    = YEAR_W'(cal_year);
        r.cal.month   = MONTH_W'(cal_month);
        r.cal.day     = DAY_W'(cal_day);
        r.cal.hour    = HOUR_W'(cal_hour);
        r.cal.minute  = MINUTE_W'(cal_min);
        r.cal.second  = SECOND_W'(cal_sec);
        r.hour_twelve = H12_W'((cal_hour % 12 == 0) ? 12 : cal_hour % 12);
        r.is_pm       = (cal_hour >= 12);
        r.status      = st;
        return r;
    endfunction

    // Idle share in percent for the current traffic phase
    function automatic int idle_share(bit sender);
        if (n_accepted < total_items / 3)
            return sender ? 12 : 53;
        else if (n_accepted < (2 * total_items) / 3)
            return sender ? 53 : 12;
        return 0;
    endfunction

    task automatic queue_beat(cmd_t c, int unsigned y, int unsigned mo, int unsigned d,
                              int unsigned h, int unsigned mi, int unsigned s);
        beat_t b;
        b.cmd    = c;
        b.year   = YEAR_W'(y);
        b.month  = MONTH_W'(mo);
        b.day    = DAY_W'(d);
        b.hour   = HOUR_W'(h);
        b.minute = MINUTE_W'(mi);
        b.second = SECOND_W'(s);
        queued_beats.push_back(b);
    endtask

    task automatic queue_ticks(int n);
        repeat (n)
            queue_beat(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Years that stress the leap rule and the upper limit
    function automatic int unsigned pick_year();
        case ($urandom_range(5))
            0:       return $urandom_range(9999, 1);
            1:       return 400 * $urandom_range(24, 1);
            2:       return 100 * $urandom_range(99, 1);
            3:       return 4 * $urandom_range(2499, 1);
            4:       return $urandom_range(9999, 9990);
            default: return $urandom_range(2100, 1890);
        endcase
    endfunction

    // Driver: present queued beats, hold while stalled, predict on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            cmd        <= 1'b0;
            set_year   <= '0;
            set_month  <= '0;
            set_day    <= '0;
            set_hour   <= '0;
            set_minute <= '0;
            set_second <= '0;
            cal_year  = 2000;
            cal_month = 1;
            cal_day   = 1;
            cal_hour  = 0;
            cal_min   = 0;
            cal_sec   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                sent_beat.cmd    = cmd_t'(cmd);
                sent_beat.year   = set_year;
                sent_beat.month  = set_month;
                sent_beat.day    = set_day;
                sent_beat.hour   = set_hour;
                sent_beat.minute = set_minute;
                sent_beat.second = set_second;
                pending_readings.push_back(advance_calendar(sent_beat));
                n_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (queued_beats.size() > 0 && $urandom_range(99) >= idle_share(1'b1))
                begin
                    next_beat = queued_beats.pop_front();
                    in_valid   <= 1'b1;
                    cmd        <= next_beat.cmd;
                    set_year   <= next_beat.year;
                    set_month  <= next_beat.month;
                    set_day    <= next_beat.day;
                    set_hour   <= next_beat.hour;
                    set_minute <= next_beat.minute;
                    set_second <= next_beat.second;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: random stall, compare each reading with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_r.cal.year    = year_out;
                got_r.cal.month   = month_out;
                got_r.cal.day     = day_out;
                got_r.cal.hour    = hour_out;
                got_r.cal.minute  = minute_out;
                got_r.cal.second  = second_out;
                got_r.hour_twelve = hour_twelve;
                got_r.is_pm       = is_pm;
                got_r.status      = status_t'(status);
                if (pending_readings.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: reading with none expected: %0d-%0d-%0d %0d:%0d:%0d st=%0d",
                                 $realtime, year_out, month_out, day_out, hour_out,
                                 minute_out, second_out, status);
                end
                else
                begin
                    want_r = pending_readings.pop_front();
                    n_checked++;
                    if (got_r.cal.year !== want_r.cal.year
                        || got_r.cal.month !== want_r.cal.month
                        || got_r.cal.day !== want_r.cal.day
                        || got_r.cal.hour !== want_r.cal.hour
                        || got_r.cal.minute !== want_r.cal.minute
                        || got_r.cal.second !== want_r.cal.second
                        || got_r.hour_twelve !== want_r.hour_twelve
                        || got_r.is_pm !== want_r.is_pm
                        || got_r.status !== want_r.status)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                        begin
                            $display("%0t: reading %0d mismatch", $realtime, n_checked);
                            $display("  expected %0d-%0d-%0d %0d:%0d:%0d h12=%0d pm=%0d st=%0d",
                                     want_r.cal.year, want_r.cal.month, want_r.cal.day,
                                     want_r.cal.hour, want_r.cal.minute, want_r.cal.second,
                                     want_r.hour_twelve, want_r.is_pm, want_r.status);
                            $display("  actual   %0d-%0d-%0d %0d:%0d:%0d h12=%0d pm=%0d st=%0d",
                                     year_out, month_out, day_out, hour_out, minute_out,
                                     second_out, hour_twelve, is_pm, status);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < idle_share(1'b0));
        end
    end

    // Watchdog: stop when neither side has moved a beat for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                hang_count <= 0;
            else if (hang_count >= HANG_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $realtime, HANG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
            else
                hang_count <= hang_count + 1;
        end
    end

    initial
    begin
        int unsigned y, mo, d, len;
        int pick;

        // directed: leap rule, every reject code, year limit, noon
        queue_ticks(1);
        queue_beat(CMD_LOAD, 2000, 2, 28, 23, 59, 59);
        queue_ticks(1);
        queue_beat(CMD_LOAD, 1900, 2, 29, 0, 0, 0);
        queue_beat(CMD_LOAD, 2024, 2, 29, 23, 59, 59);
        queue_ticks(1);
        queue_beat(CMD_LOAD, 2023, 2, 29, 0, 0, 0);
        queue_beat(CMD_LOAD, 0, 0, 0, 31, 63, 63);
        queue_beat(CMD_LOAD, 10000, 1, 1, 0, 0, 0);
        queue_beat(CMD_LOAD, 16383, 15, 31, 31, 63, 63);
        queue_beat(CMD_LOAD, 2010, 0, 1, 0, 0, 0);
        queue_beat(CMD_LOAD, 2010, 15, 1, 24, 0, 0);
        queue_beat(CMD_LOAD, 2010, 4, 31, 0, 0, 0);
        queue_beat(CMD_LOAD, 2010, 4, 0, 0, 0, 0);
        queue_beat(CMD_LOAD, 2010, 4, 30, 24, 0, 0);
        queue_beat(CMD_LOAD, 2010, 4, 30, 23, 60, 0);
        queue_beat(CMD_LOAD, 2010, 4, 30, 23, 59, 60);
        queue_beat(CMD_LOAD, 1, 1, 1, 0, 0, 0);
        queue_beat(CMD_LOAD, 9999, 12, 31, 11, 59, 59);
        queue_ticks(1);
        queue_beat(CMD_LOAD, 9999, 12, 31, 23, 59, 59);
        queue_ticks(1);
        queue_beat(CMD_LOAD, 2021, 12, 31, 23, 59, 59);
        queue_ticks(1);

        // random: mostly a valid load near a carry followed by ticks
        while (queued_beats.size() < RANDOM_TARGET)
        begin
            pick = $urandom_range(99);
            y    = pick_year();
            mo   = $urandom_range(12, 1);
            len  = month_days(mo, y);
            d    = $urandom_range(1) ? len : $urandom_range(len, 1);
            if (pick < 55)
            begin
                queue_beat(CMD_LOAD, y, mo, d,
                           $urandom_range(1) ? 23 : ($urandom_range(1) ? 11 : $urandom_range(23)),
                           $urandom_range(3) != 0 ? 59 : $urandom_range(59),
                           $urandom_range(59, 45));
                queue_ticks($urandom_range(16, 1));
            end
            else if (pick < 70)
                queue_ticks($urandom_range(5, 1));
            else if (pick < 85)
                queue_beat(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
            else
            begin
                // one field broken, the rest valid
                case ($urandom_range(6))
                    0: queue_beat(CMD_LOAD, 0, mo, d, 0, 0, 0);
                    1: queue_beat(CMD_LOAD, $urandom_range(16383, YEAR_LIMIT + 1), mo, d,
                                  0, 0, 0);
                    2: queue_beat(CMD_LOAD, y, $urandom_range(1) ? 0 : $urandom_range(15, 13),
                                  1, 0, 0, 0);
                    3: queue_beat(CMD_LOAD, y, mo, (len == 31) ? 0 : $urandom_range(31, len + 1),
                                  0, 0, 0);
                    4: queue_beat(CMD_LOAD, y, mo, d, $urandom_range(31, 24), 0, 0);
                    5: queue_beat(CMD_LOAD, y, mo, d, 0, $urandom_range(63, 60), 0);
                    default: queue_beat(CMD_LOAD, y, mo, d, 0, 0, $urandom_range(63, 60));
                endcase
            end
        end
        total_items = queued_beats.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent and every reading back
        do
            @(negedge clk);
        while (queued_beats.size() != 0 || in_valid || pending_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d beats: %0d ticks (%0d day carries, %0d year overflows),",
                 n_accepted, n_ticks, n_day_carries, n_overflows);
        $display("%0d loads (%0d rejected); %0d readings checked, %0d failures.",
                 n_loads, n_rejected, n_checked, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ccc_pkg.sv
rtl/core/ccc_update.sv
rtl/core/calendar_clock_counter.sv
test/tb_calendar_clock_counter.sv
